// ===== rtl/core/tks_pkg.sv =====
// ----------------------------------------------------------------------------
// tks_pkg
// shared types, constants and the arctangent table for the knife sequencer
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int unsigned CordicStepsDefault = 16;
  localparam int unsigned CordicStepsMax     = 24;

  localparam int unsigned CoordW = 24;
  localparam int unsigned AngleW = 16;
  localparam int unsigned DeltaW = CoordW + 1;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;

  // angles in centidegrees
  localparam logic signed [AngleW-1:0] HalfTurn = 16'sd18000;
  localparam logic signed [AngleW:0]   FullTurn = 17'sd36000;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegSafeAngle     = 3'd0,
    RegBlendAngle    = 3'd1,
    RegBlendDistance = 3'd2,
    RegLiftHeight    = 3'd3,
    RegCuttingHeight = 3'd4,
    RegPneumaticZ    = 3'd5
  } reg_idx_e;

  // atan(2^-i) in 1/256 centidegree
  function automatic logic [23:0] atan_lut(input logic [4:0] i);
    logic [23:0] r;
    case (i)
      5'd0:  r = 24'd1152000;
      5'd1:  r = 24'd680065;
      5'd2:  r = 24'd359328;
      5'd3:  r = 24'd182400;
      5'd4:  r = 24'd91554;
      5'd5:  r = 24'd45822;
      5'd6:  r = 24'd22916;
      5'd7:  r = 24'd11459;
      5'd8:  r = 24'd5730;
      5'd9:  r = 24'd2865;
      5'd10: r = 24'd1432;
      5'd11: r = 24'd716;
      5'd12: r = 24'd358;
      5'd13: r = 24'd179;
      5'd14: r = 24'd90;
      5'd15: r = 24'd45;
      5'd16: r = 24'd22;
      5'd17: r = 24'd11;
      5'd18: r = 24'd6;
      5'd19: r = 24'd3;
      5'd20: r = 24'd1;
      5'd21: r = 24'd1;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/tks_cordic.sv =====
// ----------------------------------------------------------------------------
// tks_cordic
// iterative vectoring cordic, one rotation per cycle, heading in centidegrees
// ----------------------------------------------------------------------------
module tks_cordic #(
  parameter int unsigned STEPS = tks_pkg::CordicStepsDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [tks_pkg::DeltaW-1:0]     dx_i,
  input  logic signed [tks_pkg::DeltaW-1:0]     dy_i,
  output logic                                  done_o,
  output logic signed [tks_pkg::AngleW-1:0]     heading_o
);
  import tks_pkg::*;

  localparam int unsigned VecW = 36;
  localparam int unsigned ZW   = 24;
  localparam int unsigned CW   = $clog2(STEPS + 1);
  localparam logic signed [ZW-1:0] QuarterZ = 24'sd2304000;

  logic signed [VecW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]   z_q, z_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   run_q, run_d, zero_q, zero_d, done_q, done_d;
  logic signed [AngleW-1:0] head_q, head_d;

  logic signed [VecW-1:0] x0, y0, xs, ys;
  logic signed [ZW-1:0]   step_z, zr, nz;

  // scaled start vector
  assign x0 = {{3{dx_i[DeltaW-1]}}, dx_i, 8'b0};
  assign y0 = {{3{dy_i[DeltaW-1]}}, dy_i, 8'b0};
  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign step_z = $signed(atan_lut(5'(cnt_q)));

  // round half away from zero
  assign nz = -z_q;
  assign zr = (z_q >= 0) ? ((z_q + 24'sd128) >>> 8) : -((nz + 24'sd128) >>> 8);

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    cnt_d = cnt_q;
    run_d = run_q;
    zero_d = zero_q;
    done_d = 1'b0;
    head_d = head_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      zero_d = (dx_i == '0) && (dy_i == '0);
      if (dx_i < 0) begin
        if (dy_i >= 0) begin
          x_d = y0;
          y_d = -x0;
          z_d = QuarterZ;
        end else begin
          x_d = -y0;
          y_d = x0;
          z_d = -QuarterZ;
        end
      end else begin
        x_d = x0;
        y_d = y0;
        z_d = '0;
      end
    end else if (run_q) begin
      if (cnt_q == CW'(STEPS)) begin
        run_d = 1'b0;
        done_d = 1'b1;
        if (zero_q) begin
          head_d = '0;
        end else if (zr > 24'sd18000) begin
          head_d = HalfTurn;
        end else if (zr < -24'sd18000) begin
          head_d = -HalfTurn;
        end else begin
          head_d = AngleW'(zr);
        end
      end else begin
        cnt_d = cnt_q + 1'b1;
        if (y_q > 0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + step_z;
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - step_z;
        end
      end
    end
  end

  // control and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    zero_q <= zero_d;
    head_q <= head_d;
  end

  assign done_o = done_q;
  assign heading_o = head_q;

endmodule

// ===== rtl/core/tangential_knife_move_sequencer.sv =====
// ----------------------------------------------------------------------------
// tangential_knife_move_sequencer
// expands one requested move into up to five knife-aligned axis moves
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o | target xyz, pos xyzc, is_rapid
//  out     | output    | out_valid_o/out_ready_i | move xyzc, last_move
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  after its accept, a transaction runs the shared cordic twice, for the new
//  heading and then the old one, before its first move, then gives one move
//  per cycle while out_ready_i is high; squared lengths come from bit-serial
//  multipliers, and S_WAIT holds until they finish. reset clears control and
//  loads register defaults; stalls on out hold the current move.
module tangential_knife_move_sequencer #(
  parameter int unsigned CORDIC_STEPS = tks_pkg::CordicStepsDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tks_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [tks_pkg::CfgDataW-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [tks_pkg::CoordW-1:0]     target_x_i,
  input  logic signed [tks_pkg::CoordW-1:0]     target_y_i,
  input  logic signed [tks_pkg::CoordW-1:0]     target_z_i,
  input  logic signed [tks_pkg::CoordW-1:0]     pos_x_i,
  input  logic signed [tks_pkg::CoordW-1:0]     pos_y_i,
  input  logic signed [tks_pkg::CoordW-1:0]     pos_z_i,
  input  logic signed [tks_pkg::AngleW-1:0]     pos_c_i,
  input  logic                                  is_rapid_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [tks_pkg::CoordW-1:0]     move_x_o,
  output logic signed [tks_pkg::CoordW-1:0]     move_y_o,
  output logic signed [tks_pkg::CoordW-1:0]     move_z_o,
  output logic signed [tks_pkg::AngleW-1:0]     move_c_o,
  output logic                                  last_move_o
);
  import tks_pkg::*;

  localparam int unsigned MulW  = DeltaW;
  localparam int unsigned SqW   = 2 * DeltaW;
  localparam int unsigned BdW   = 23;
  localparam int unsigned BdSqW = 2 * BdW;
  localparam int unsigned MCntW = $clog2(MulW + 1);
  localparam int unsigned NSlot = 5;

  typedef enum logic [2:0] {S_IDLE, S_NEW, S_OLD, S_WAIT, S_OUT} state_e;

  // configuration registers
  logic [14:0]              safe_q, blend_a_q;
  logic [BdW-1:0]           blend_d_q;
  logic signed [CoordW-1:0] lift_q, cut_q;
  logic                     pneu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safe_q <= 15'd3000;
      blend_a_q <= 15'd1000;
      blend_d_q <= 23'd1000;
      lift_q <= 24'sd5000;
      cut_q <= '0;
      pneu_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        RegSafeAngle:     safe_q <= cfg_data_i[14:0];
        RegBlendAngle:    blend_a_q <= cfg_data_i[14:0];
        RegBlendDistance: blend_d_q <= cfg_data_i[BdW-1:0];
        RegLiftHeight:    lift_q <= $signed(cfg_data_i);
        RegCuttingHeight: cut_q <= $signed(cfg_data_i);
        RegPneumaticZ:    pneu_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  state_e state_q;
  logic signed [CoordW-1:0] tx_q, ty_q, tz_q, px_q, py_q, pz_q, prevx_q, prevy_q;
  logic signed [AngleW-1:0] pc_q, new_h_q, old_h_q;
  logic                     prev_v_q, e0_q, start_q, out_v_q, path_a_q;
  logic signed [DeltaW-1:0] dx_q, dy_q;
  logic [NSlot-1:0]         pend_q;
  logic signed [CoordW-1:0] mx_q, my_q, mz_q;
  logic signed [AngleW-1:0] mc_q;
  logic                     ml_q;

  // bit-serial squaring of the move and the blend distance
  logic [SqW-1:0]   accx_q, accy_q, mcx_q, mcy_q;
  logic [MulW-1:0]  mrx_q, mry_q;
  logic [BdSqW-1:0] accb_q, mcb_q;
  logic [BdW-1:0]   mrb_q;
  logic [MCntW-1:0] mcnt_q;

  logic accept;
  logic start_d;
  logic signed [CoordW-1:0] tz_eff;
  logic signed [DeltaW-1:0] ndx, ndy, odx, ody, cdx, cdy;
  logic [MulW-1:0] adx, ady;
  logic c_done;
  logic signed [AngleW-1:0] c_head;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  // cordic start for the new heading, then for the old one
  assign start_d = ((state_q == S_IDLE) && accept) || ((state_q == S_NEW) && c_done);
  assign tz_eff = pneu_q ? (is_rapid_i ? lift_q : cut_q) : target_z_i;
  assign ndx = DeltaW'(target_x_i) - DeltaW'(pos_x_i);
  assign ndy = DeltaW'(target_y_i) - DeltaW'(pos_y_i);
  assign adx = ndx[DeltaW-1] ? MulW'(-ndx) : MulW'(ndx);
  assign ady = ndy[DeltaW-1] ? MulW'(-ndy) : MulW'(ndy);
  assign odx = DeltaW'(px_q) - DeltaW'(prevx_q);
  assign ody = DeltaW'(py_q) - DeltaW'(prevy_q);
  assign cdx = (state_q == S_OLD) ? odx : dx_q;
  assign cdy = (state_q == S_OLD) ? ody : dy_q;

  tks_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_q),
    .dx_i(cdx), .dy_i(cdy), .done_o(c_done), .heading_o(c_head)
  );

  // heading difference wrapped to a half turn
  logic signed [AngleW:0] diff_raw, diff_w, diff_abs;
  logic path_a, path_c;
  assign diff_raw = (AngleW+1)'(new_h_q) - (AngleW+1)'(old_h_q);
  always_comb begin
    diff_w = diff_raw;
    if (diff_raw > 17'sd18000) diff_w = diff_raw - FullTurn;
    if (diff_raw < -17'sd18000) diff_w = diff_raw + FullTurn;
    diff_abs = diff_w[AngleW] ? -diff_w : diff_w;
  end
  assign path_a = diff_abs > $signed({2'b0, safe_q});
  assign path_c = !((diff_abs <= $signed({2'b0, blend_a_q}))
                    && ((SqW+1)'(accx_q) + (SqW+1)'(accy_q) <= (SqW+1)'(accb_q)));

  // lowest pending move
  logic [2:0] slot;
  always_comb begin
    slot = 3'd4;
    if (pend_q[0]) slot = 3'd0;
    else if (pend_q[1]) slot = 3'd1;
    else if (pend_q[2]) slot = 3'd2;
    else if (pend_q[3]) slot = 3'd3;
  end

  // sequencer, serial multipliers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= 1'b0;
      out_v_q <= 1'b0;
      prev_v_q <= 1'b0;
      prevx_q <= '0;
      prevy_q <= '0;
      pend_q <= '0;
      mcnt_q <= '0;
      tx_q <= '0;
      ty_q <= '0;
      tz_q <= '0;
      px_q <= '0;
      py_q <= '0;
      pz_q <= '0;
      pc_q <= '0;
      new_h_q <= '0;
      old_h_q <= '0;
      e0_q <= 1'b0;
      path_a_q <= 1'b0;
      dx_q <= '0;
      dy_q <= '0;
      mx_q <= '0;
      my_q <= '0;
      mz_q <= '0;
      mc_q <= '0;
      ml_q <= 1'b0;
      accx_q <= '0;
      accy_q <= '0;
      accb_q <= '0;
      mcx_q <= '0;
      mcy_q <= '0;
      mcb_q <= '0;
      mrx_q <= '0;
      mry_q <= '0;
      mrb_q <= '0;
    end else begin
      start_q <= start_d;
      if (mcnt_q != '0) begin
        mcnt_q <= mcnt_q - 1'b1;
        if (mrx_q[0]) accx_q <= accx_q + mcx_q;
        if (mry_q[0]) accy_q <= accy_q + mcy_q;
        if (mrb_q[0]) accb_q <= accb_q + mcb_q;
        mrx_q <= mrx_q >> 1;
        mry_q <= mry_q >> 1;
        mrb_q <= mrb_q >> 1;
        mcx_q <= mcx_q << 1;
        mcy_q <= mcy_q << 1;
        mcb_q <= mcb_q << 1;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            tx_q <= target_x_i;
            ty_q <= target_y_i;
            tz_q <= tz_eff;
            px_q <= pos_x_i;
            py_q <= pos_y_i;
            pz_q <= pneu_q ? tz_eff : pos_z_i;
            pc_q <= pos_c_i;
            e0_q <= pneu_q && (pos_z_i != tz_eff);
            dx_q <= ndx;
            dy_q <= ndy;
            if (!prev_v_q) begin
              prevx_q <= pos_x_i;
              prevy_q <= pos_y_i;
            end
            accx_q <= '0;
            accy_q <= '0;
            accb_q <= '0;
            mrx_q <= adx;
            mry_q <= ady;
            mrb_q <= blend_d_q;
            mcx_q <= SqW'(adx);
            mcy_q <= SqW'(ady);
            mcb_q <= BdSqW'(blend_d_q);
            mcnt_q <= MCntW'(MulW);
            state_q <= S_NEW;
          end
        end
        S_NEW: begin
          if (c_done) begin
            new_h_q <= c_head;
            state_q <= S_OLD;
          end
        end
        S_OLD: begin
          if (c_done) begin
            old_h_q <= c_head;
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mcnt_q == '0) begin
            path_a_q <= path_a;
            pend_q <= {1'b1,
                       path_a && (lift_q != cut_q),
                       (path_a || path_c) && (pc_q != new_h_q),
                       path_a && (pz_q != lift_q),
                       e0_q};
            prevx_q <= px_q;
            prevy_q <= py_q;
            prev_v_q <= 1'b1;
            out_v_q <= 1'b0;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_v_q || out_ready_i) begin
            if (pend_q != '0) begin
              out_v_q <= 1'b1;
              pend_q[slot] <= 1'b0;
              mx_q <= (slot == 3'd4) ? tx_q : px_q;
              my_q <= (slot == 3'd4) ? ty_q : py_q;
              ml_q <= (slot == 3'd4);
              case (slot)
                3'd0: begin
                  mz_q <= pz_q;
                  mc_q <= pc_q;
                end
                3'd1: begin
                  mz_q <= lift_q;
                  mc_q <= pc_q;
                end
                3'd2: begin
                  mz_q <= path_a_q ? lift_q : pz_q;
                  mc_q <= new_h_q;
                end
                3'd3: begin
                  mz_q <= cut_q;
                  mc_q <= new_h_q;
                end
                default: begin
                  mz_q <= tz_q;
                  mc_q <= new_h_q;
                end
              endcase
            end else begin
              out_v_q <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign move_x_o = mx_q;
  assign move_y_o = my_q;
  assign move_z_o = mz_q;
  assign move_c_o = mc_q;
  assign last_move_o = ml_q;

endmodule
